@@ hw/rtl/byte_stuffing_frame_encoder_unit_defines.svh @@
// Assertion macros shared by the verification code of the frame encoder.
`ifndef BYTE_STUFFING_FRAME_ENCODER_UNIT_DEFINES_SVH
`define BYTE_STUFFING_FRAME_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame encoder check failed");

// Next-cycle implication, checked outside reset.
`define BSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame encoder check failed");

`endif

@@ hw/rtl/bsfe_pkg.sv @@
package bsfe_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_SLOTS = 6;
    localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

    // Fixed order of the bytes that one payload byte can cause.
    localparam int unsigned SLOT_START   = 0;
    localparam int unsigned SLOT_ESC_B   = 1;
    localparam int unsigned SLOT_BYTE    = 2;
    localparam int unsigned SLOT_ESC_SUM = 3;
    localparam int unsigned SLOT_SUM     = 4;
    localparam int unsigned SLOT_END     = 5;

    localparam logic [BYTE_W-1:0] OPEN_BYTE_RST  = 8'h02;
    localparam logic [BYTE_W-1:0] ESC_BYTE_RST   = 8'h10;
    localparam logic [BYTE_W-1:0] CLOSE_BYTE_RST = 8'h03;
    localparam logic [BYTE_W-1:0] XOR_INIT       = 8'h00;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_BYTE  = 2'd0,
        CFG_ESC_BYTE   = 2'd1,
        CFG_CLOSE_BYTE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              run_last;
    } t_out;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes;
        logic [NUM_SLOTS-1:0]             mask;
    } t_burst;

endpackage

@@ hw/rtl/bsfe_encode.sv @@
module bsfe_encode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsfe_pkg::BYTE_W-1:0]     i_cfg_data,
    input  bsfe_pkg::t_in                   i_item,
    input  logic                            i_accept,
    output bsfe_pkg::t_burst                o_burst
);
    import bsfe_pkg::*;

    logic [BYTE_W-1:0] r_open_byte;
    logic [BYTE_W-1:0] r_esc_byte;
    logic [BYTE_W-1:0] r_close_byte;
    logic              r_inside;
    logic [BYTE_W-1:0] r_xor;

    logic [BYTE_W-1:0] n_xor;
    logic              spec_byte;
    logic              spec_sum;

    always_comb begin
        n_xor     = r_xor ^ i_item.payload_byte;
        spec_byte = (i_item.payload_byte == r_open_byte)
                  | (i_item.payload_byte == r_esc_byte)
                  | (i_item.payload_byte == r_close_byte);
        spec_sum  = (n_xor == r_open_byte) | (n_xor == r_esc_byte)
                  | (n_xor == r_close_byte);

        o_burst.bytes[SLOT_START]   = r_open_byte;
        o_burst.bytes[SLOT_ESC_B]   = r_esc_byte;
        o_burst.bytes[SLOT_BYTE]    = i_item.payload_byte;
        o_burst.bytes[SLOT_ESC_SUM] = r_esc_byte;
        o_burst.bytes[SLOT_SUM]     = n_xor;
        o_burst.bytes[SLOT_END]     = r_close_byte;

        o_burst.mask[SLOT_START]   = !r_inside;
        o_burst.mask[SLOT_ESC_B]   = spec_byte;
        o_burst.mask[SLOT_BYTE]    = 1'b1;
        o_burst.mask[SLOT_ESC_SUM] = i_item.frame_last & spec_sum;
        o_burst.mask[SLOT_SUM]     = i_item.frame_last;
        o_burst.mask[SLOT_END]     = i_item.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_byte  <= OPEN_BYTE_RST;
            r_esc_byte   <= ESC_BYTE_RST;
            r_close_byte <= CLOSE_BYTE_RST;
            r_inside     <= 1'b0;
            r_xor        <= XOR_INIT;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OPEN_BYTE:  r_open_byte  <= i_cfg_data;
                    CFG_ESC_BYTE:   r_esc_byte   <= i_cfg_data;
                    CFG_CLOSE_BYTE: r_close_byte <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (i_accept) begin
                if (i_item.frame_last) begin
                    r_inside <= 1'b0;
                    r_xor    <= XOR_INIT;
                end else begin
                    r_inside <= 1'b1;
                    r_xor    <= n_xor;
                end
            end
        end
    end

endmodule

@@ hw/rtl/bsfe_serial.sv @@
module bsfe_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsfe_pkg::t_burst i_burst,
    input  logic             i_load,
    output logic             o_load_ok,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bsfe_pkg::t_out   o_out_data
);
    import bsfe_pkg::*;

    logic [NUM_SLOTS-1:0][BYTE_W-1:0] r_bytes;
    logic [NUM_SLOTS-1:0]             r_mask;
    logic                             r_out_valid;
    t_out                             r_out;

    logic [SLOT_W-1:0]    sel;
    logic [NUM_SLOTS-1:0] rest;
    logic                 rest_empty;
    logic                 move;

    // The lowest pending slot is the next byte on the line.
    always_comb begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
        rest       = r_mask;
        rest[sel]  = 1'b0;
        rest_empty = (rest == '0);
        move       = (r_mask != '0) && (!r_out_valid || i_out_ready);
        o_load_ok  = (r_mask == '0) || (move && rest_empty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_burst.mask;
            end else if (move) begin
                r_mask <= rest;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
        end
        if (move) begin
            r_out.line_byte <= r_bytes[sel];
            r_out.run_last  <= rest_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/byte_stuffing_frame_encoder_unit.sv @@
// Byte-stuffing frame encoder with an XOR checksum. Raw payload bytes come in
// one per transfer, each with a flag that marks the last byte of its frame.
// The first byte of a frame is preceded by the start character, and every
// payload byte that equals the start, escape or end character is preceded by
// the escape character. After the last byte the block sends the XOR of all
// raw payload bytes of the frame, escaped the same way, and then the end
// character. One input transfer therefore causes one to six output
// transfers; run_last marks the final one of them. The three framing
// characters are written through the configuration port (index 0 start,
// 1 escape, 2 end; index 3 is ignored) and should only change while the
// block is idle. Throughput is one output byte per clock while the output
// is not stalled, so a plain mid-frame byte goes through at one per cycle.
// The encoded bytes of an input wait in a six-slot burst register that
// drains one slot a cycle into the output register unless the output
// stalls; the next input transfer is taken in the cycle the burst register
// hands over its last byte, so there are no idle cycles between items. The
// first line byte of an item passes through the burst register and then
// the output register before it appears on the output. Frames have no
// length limit.
module byte_stuffing_frame_encoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsfe_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bsfe_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bsfe_pkg::t_out                 o_out_data
);
    import bsfe_pkg::*;

    t_burst burst;
    logic   load_ok;
    logic   accept;

    // An input transfer completes when the burst register is free or is
    // handing over its last pending byte in this cycle.
    assign accept     = i_in_valid && load_ok;
    assign o_in_ready = load_ok;

    // Framing state, configuration registers and the encode logic that turns
    // one payload byte into its set of line bytes.
    bsfe_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_accept   (accept),
        .o_burst    (burst)
    );

    // Burst register and output register: sends the pending line bytes in
    // slot order, one per cycle while the output is not stalled.
    bsfe_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_burst     (burst),
        .i_load      (accept),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/bsfe_checker.sv @@
`include "byte_stuffing_frame_encoder_unit_defines.svh"

module bsfe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input bsfe_pkg::t_out                 o_out_data
);
    import bsfe_pkg::*;

    logic in_xfer;
    logic out_stall;
    logic quiet;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign quiet     = i_rst_n && !o_out_valid && !in_xfer;

    // A stalled result keeps its valid and its payload.
    `BSFE_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, out_stall, o_out_valid)
    `BSFE_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, out_stall, $stable(o_out_data))

    // An accepted byte is followed by valid output after the burst and output registers.
    `BSFE_ASSERT_NOW(a_in_to_out, i_clk, i_rst_n, in_xfer, ##2 o_out_valid)

    // With nothing taken in and nothing on the output, the block must be free.
    `BSFE_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !o_out_valid && $past(quiet), o_in_ready)

endmodule

bind byte_stuffing_frame_encoder_unit bsfe_checker u_bsfe_checker (.*);

@@ test/byte_stuffing_frame_encoder_unit_tb.sv @@
module byte_stuffing_frame_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfe_pkg::*;

    // The port carries two index bits, so one index selects no register at all.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Predicts the encoded line bytes and holds them until the block sends them.
    class line_byte_predictor;
        logic [BYTE_W-1:0] open_byte;
        logic [BYTE_W-1:0] esc_byte;
        logic [BYTE_W-1:0] close_byte;
        bit                in_frame;
        logic [BYTE_W-1:0] frame_xor;
        t_out              expected_line[$];
        int unsigned       mismatches;

        function new();
            open_byte  = OPEN_BYTE_RST;
            esc_byte   = ESC_BYTE_RST;
            close_byte = CLOSE_BYTE_RST;
            in_frame   = 1'b0;
            frame_xor  = XOR_INIT;
            mismatches = 0;
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
            case (idx)
                CFG_OPEN_BYTE: begin
                    open_byte = value;
                end
                CFG_ESC_BYTE: begin
                    esc_byte = value;
                end
                CFG_CLOSE_BYTE: begin
                    close_byte = value;
                end
                default: begin
                end
            endcase
        endfunction

        function bit is_framing(logic [BYTE_W-1:0] b);
            return b == open_byte || b == esc_byte || b == close_byte;
        endfunction

        function void push_line(logic [BYTE_W-1:0] b);
            t_out entry;
            entry.line_byte = b;
            entry.run_last  = 1'b0;
            expected_line.push_back(entry);
        endfunction

        // A byte that matches any framing character goes out behind one escape.
        function void push_escaped(logic [BYTE_W-1:0] b);
            if (is_framing(b)) begin
                push_line(esc_byte);
            end
            push_line(b);
        endfunction

        function void accept_payload(t_in item);
            t_out tail;
            if (!in_frame) begin
                push_line(open_byte);
            end
            push_escaped(item.payload_byte);
            frame_xor ^= item.payload_byte;
            if (item.frame_last) begin
                push_escaped(frame_xor);
                push_line(close_byte);
                in_frame  = 1'b0;
                frame_xor = XOR_INIT;
            end else begin
                in_frame = 1'b1;
            end
            // The final byte caused by this transfer carries the run marker.
            tail = expected_line.pop_back();
            tail.run_last = 1'b1;
            expected_line.push_back(tail);
        endfunction

        task check_line_byte(t_out got);
            t_out want;
            if (expected_line.size() == 0) begin
                report($sformatf("line byte 0x%02h (run_last %0b) with nothing expected",
                                 got.line_byte, got.run_last));
                return;
            end
            want = expected_line.pop_front();
            if (got.line_byte !== want.line_byte) begin
                report($sformatf("line_byte 0x%02h, expected 0x%02h",
                                 got.line_byte, want.line_byte));
            end
            if (got.run_last !== want.run_last) begin
                report($sformatf("run_last %0b on line byte 0x%02h, expected %0b",
                                 got.run_last, got.line_byte, want.run_last));
            end
        endtask

        task check_leftovers();
            if (expected_line.size() != 0) begin
                report($sformatf("%0d line bytes never arrived", expected_line.size()));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out                 o_out_data;

    // When set, neither side inserts any gaps, so the block runs back to back.
    bit no_idle_stretch = 1'b0;

    line_byte_predictor encoder;

    byte_stuffing_frame_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Most gaps are zero or short; now and then a long one falls in.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle_stretch || roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 2);
        end else if (roll < 97) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_framing_char();
        case ($urandom_range(0, 2))
            0: return encoder.open_byte;
            1: return encoder.esc_byte;
            default: return encoder.close_byte;
        endcase
    endfunction

    // Framing characters and the extreme values turn up far more often than
    // they would with a flat spread, so the escape path is well exercised.
    function automatic logic [BYTE_W-1:0] pick_payload_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return pick_framing_char();
        end else if (roll < 35) begin
            return 8'h00;
        end else if (roll < 40) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one payload byte and returns at the edge where it is accepted.
    // Valid stays high when the next transfer follows without a gap.
    task automatic send_payload(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        t_in         item;
        gap = pick_gap();
        item.payload_byte = b;
        item.frame_last   = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        encoder.accept_payload(item);
    endtask

    // Stops offering input and waits until every predicted line byte is out.
    task automatic drain_line();
        in_valid <= 1'b0;
        while (encoder.expected_line.size() != 0) @(posedge i_clk);
    endtask

    // Writes all three framing characters on consecutive edges. The write
    // enable is lowered only after the last one, so it never toggles within
    // a single time step. Optionally a write to the unused index follows.
    task automatic program_framing(input logic [BYTE_W-1:0] start_value,
                                   input logic [BYTE_W-1:0] escape_value,
                                   input logic [BYTE_W-1:0] end_value,
                                   input bit                poke_unused);
        t_cfg_idx          order[3];
        logic [BYTE_W-1:0] values[3];
        order  = '{CFG_OPEN_BYTE, CFG_ESC_BYTE, CFG_CLOSE_BYTE};
        values = '{start_value, escape_value, end_value};
        for (int i = 0; i < 3; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= order[i];
            cfg_data <= values[i];
            @(posedge i_clk);
            encoder.set_register(order[i], values[i]);
        end
        if (poke_unused) begin
            cfg_idx  <= CFG_UNUSED_IDX;
            cfg_data <= ~start_value;
            @(posedge i_clk);
            encoder.set_register(CFG_UNUSED_IDX, ~start_value);
        end
        cfg_we <= 1'b0;
    endtask

    // Random frames: mostly short, some long, occasionally cut short by an
    // early last flag. The closing byte is sometimes picked so that the
    // checksum itself lands on a framing character and needs an escape.
    task automatic send_random_payload(input int unsigned count);
        int unsigned       left_in_frame;
        logic [BYTE_W-1:0] b;
        logic              last;
        left_in_frame = 0;
        for (int unsigned n = 0; n < count; n++) begin
            if (left_in_frame == 0) begin
                left_in_frame = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                            : $urandom_range(1, 6);
            end
            b    = pick_payload_byte();
            last = (left_in_frame == 1) || ($urandom_range(0, 29) == 0);
            if (last && $urandom_range(0, 3) == 0) begin
                b = encoder.frame_xor ^ pick_framing_char();
            end
            left_in_frame = last ? 0 : left_in_frame - 1;
            send_payload(b, last);
        end
    endtask

    // The sink takes line bytes with random stalls and checks every transfer.
    initial begin : line_sink
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_out_valid === 1'b1 && out_ready) begin
                encoder.check_line_byte(o_out_data);
            end
            if (stall == 0 && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] shared;
        encoder = new();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset characters: start 0x02, escape 0x10, end 0x03.
        // A one-byte frame whose byte and checksum are both special gives
        // the longest run of six line bytes.
        send_payload(8'h02, 1'b1);
        // Both byte extremes and every framing character inside one frame.
        send_payload(8'h00, 1'b0);
        send_payload(8'hFF, 1'b0);
        send_payload(8'h10, 1'b0);
        send_payload(8'h03, 1'b0);
        send_payload(8'h02, 1'b1);
        // The checksum comes out equal to the escape character.
        send_payload(8'h11, 1'b0);
        send_payload(8'h01, 1'b1);
        // The checksum cancels to zero.
        send_payload(8'h5A, 1'b0);
        send_payload(8'h5A, 1'b1);
        // The checksum equals the end character.
        send_payload(8'h03, 1'b1);

        // The characters change in the middle of a frame: bytes already sent
        // keep the old encoding and the rest of the frame uses the new one.
        send_payload(8'h80, 1'b0);
        send_payload(8'h7F, 1'b0);
        drain_line();
        program_framing(8'h00, 8'hFF, 8'h7E, 1'b0);
        send_payload(8'h00, 1'b0);
        send_payload(8'hFF, 1'b0);
        send_payload(8'h7E, 1'b0);
        send_payload(8'h10, 1'b1);

        // All three characters share one value; a matching byte is still
        // escaped only once. The write to the unused index must change nothing.
        drain_line();
        program_framing(8'h55, 8'h55, 8'h55, 1'b1);
        send_payload(8'h55, 1'b1);
        send_payload(8'hAA, 1'b0);
        send_payload(8'hFF, 1'b1);

        // Random phases, each under its own set of characters.
        drain_line();
        program_framing(OPEN_BYTE_RST, ESC_BYTE_RST, CLOSE_BYTE_RST, 1'b0);
        send_random_payload(40);

        drain_line();
        no_idle_stretch = 1'b1;
        program_framing(8'hFF, 8'h00, 8'h80, 1'b0);
        send_random_payload(40);

        drain_line();
        no_idle_stretch = 1'b0;
        program_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'b1);
        send_random_payload(40);

        drain_line();
        shared = 8'($urandom_range(0, 255));
        program_framing(shared, shared, shared, 1'b0);
        send_random_payload(40);

        drain_line();
        program_framing(8'h00, 8'h00, 8'hFF, 1'b0);
        send_random_payload(40);

        drain_line();
        program_framing(8'h7E, 8'h7D, 8'h7F, 1'b0);
        send_random_payload(40);

        drain_line();
        // A few extra cycles catch any line byte the block sends unprompted.
        repeat (16) @(posedge i_clk);
        encoder.check_leftovers();
        if (encoder.mismatches == 0) begin
            $display("** byte_stuffing_frame_encoder_unit: PASSED **");
        end else begin
            $display("** byte_stuffing_frame_encoder_unit: FAILED **");
        end
        $finish;
    end

    // Far beyond the slowest legal run: every transfer at six line bytes,
    // each behind the longest stall, plus the longest input gaps.
    initial begin : watchdog
        #5000000;
        $display("** byte_stuffing_frame_encoder_unit: FAILED **");
        $finish;
    end

endmodule
